@@ src/escape_time_palette_colorer_core_assert.svh @@
// assertion macros used by the colorer back part
// expects clk and rst_n in the scope of each use
`ifndef ESCAPE_TIME_PALETTE_COLORER_CORE_ASSERT_SVH
`define ESCAPE_TIME_PALETTE_COLORER_CORE_ASSERT_SVH

// same-cycle implication
`define ETPC_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("etpc assertion failed");

// next-cycle implication
`define ETPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etpc assertion failed");

`endif

@@ src/etpc_pkg.sv @@
// shared types and constants of the escape time palette colorer
// no dependencies
package etpc_pkg;

    localparam int PALETTE_DEPTH_DEF  = 256;
    localparam int MAX_ITERATIONS_DEF = 1024;
    localparam int QUEUE_DEPTH        = 4;
    localparam int SIZE_W             = 9;
    localparam int DIV_W              = 39;
    localparam int REM_W              = 32;
    localparam int FRAC_W             = 18;
    localparam int HIST_SCALE         = 99;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_COUNT = 2'd2,
        OP_COLOR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_BICOLOR = 2'd0,
        MODE_ESCAPE  = 2'd1,
        MODE_DIST    = 2'd2,
        MODE_HIST    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_COLOR_MODE = 2'd0,
        CFG_CONV_COLOR = 2'd1,
        CFG_DIV_COLOR  = 2'd2,
        CFG_PAL_SIZE   = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        K_WRITE,
        K_CLEAR,
        K_COUNT,
        K_CONST,
        K_ESCAPE,
        K_DIST,
        K_HIST
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               hit;
        logic [9:0]         iter;
        logic [19:0]        dist_est;
        logic [7:0]         entry;
        logic [23:0]        rgb;
        logic [SIZE_W-1:0]  size;
    } task_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_MUL,
        ST_HRD,
        ST_HMUL,
        ST_QSTART,
        ST_DIV1,
        ST_MOD_START,
        ST_DIV2,
        ST_RD,
        ST_FIN,
        ST_BLEND
    } st_t;

endpackage

@@ src/etpc_queue.sv @@
// task queue between the front and back parts
// depends on etpc_pkg
module etpc_queue
    import etpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  task_t   wdata,
    input  logic    rd,
    output task_t   head,
    output q_stat_t stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    task_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign stat.full  = (cnt_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ src/etpc_front.sv @@
// front part: configuration registers and classification of input words
// depends on etpc_pkg
module etpc_front
    import etpc_pkg::*;
#(
    parameter int PALETTE_DEPTH  = PALETTE_DEPTH_DEF,
    parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  opcode,
    input  logic        converged,
    input  logic [9:0]  iteration_count,
    input  logic [19:0] distance_estimate,
    input  logic [7:0]  entry_index,
    input  logic [23:0] entry_rgb,
    output logic        q_wr,
    output task_t       q_wdata
);

    logic [1:0]         mode_reg;
    logic [23:0]        conv_reg;
    logic [23:0]        div_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [SIZE_W-1:0]  used_size;
    logic               keep;
    logic               in_hist;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BICOLOR;
            conv_reg <= '0;
            div_reg  <= 24'hFFFFFF;
            size_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_COLOR_MODE: mode_reg <= cfg_data[1:0];
                CFG_CONV_COLOR: conv_reg <= cfg_data;
                CFG_DIV_COLOR:  div_reg  <= cfg_data;
                CFG_PAL_SIZE:   size_reg <= cfg_data[SIZE_W-1:0];
                default:        mode_reg <= mode_reg;
            endcase
        end
    end

    // palette size saturates at the depth
    assign used_size = (32'(size_reg) > 32'(PALETTE_DEPTH)) ? SIZE_W'(PALETTE_DEPTH) : size_reg;
    assign in_hist   = (32'(iteration_count) < 32'(MAX_ITERATIONS));

    // classify the word, drop words with no effect
    always_comb
    begin
        q_wdata.kind     = K_CONST;
        q_wdata.hit      = in_hist;
        q_wdata.iter     = iteration_count;
        q_wdata.dist_est = distance_estimate;
        q_wdata.entry    = entry_index;
        q_wdata.rgb      = entry_rgb;
        q_wdata.size     = used_size;
        keep             = 1'b1;
        unique case (op_t'(opcode))
            OP_WRITE:
            begin
                q_wdata.kind = K_WRITE;
                keep         = (32'(entry_index) < 32'(PALETTE_DEPTH));
            end
            OP_CLEAR:
            begin
                q_wdata.kind = K_CLEAR;
            end
            OP_COUNT:
            begin
                q_wdata.kind = K_COUNT;
                keep         = !converged && in_hist;
            end
            default:
            begin
                if (converged)
                begin
                    q_wdata.rgb = conv_reg;
                end
                else if (mode_reg == MODE_BICOLOR)
                begin
                    q_wdata.rgb = div_reg;
                end
                else if (used_size == '0)
                begin
                    q_wdata.rgb = '0;
                end
                else if (mode_reg == MODE_ESCAPE)
                begin
                    q_wdata.kind = K_ESCAPE;
                end
                else if (mode_reg == MODE_DIST)
                begin
                    q_wdata.kind = K_DIST;
                end
                else
                begin
                    q_wdata.kind = K_HIST;
                end
            end
        endcase
    end

    assign q_wr = push && !full && keep;

endmodule

@@ src/etpc_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on etpc_pkg
module etpc_div
    import etpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [REM_W-1:0] divisor,
    output div_stat_t        stat,
    output logic [DIV_W-1:0] quotient,
    output logic [REM_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DIV_W);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] dvs_reg;
    logic [REM_W:0]   shifted;
    logic [REM_W:0]   diff;
    logic             ge;

    // one subtract and compare step
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ src/etpc_back.sv @@
// back part: palette and histogram memories, color sequencer, result register
// depends on etpc_pkg, etpc_div and the assertion header
`include "escape_time_palette_colorer_core_assert.svh"
module etpc_back
    import etpc_pkg::*;
#(
    parameter int PALETTE_DEPTH  = PALETTE_DEPTH_DEF,
    parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  task_t       head,
    input  q_stat_t     q_stat,
    output logic        q_rd,
    output logic        init_busy,
    output logic        empty,
    input  logic        pop,
    output logic [23:0] pixel_rgb
);

    localparam int PW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int IW = $clog2(MAX_ITERATIONS);

    st_t                state_reg, state_next;
    task_t              cur_reg, cur_next;
    logic               init_reg, init_next;
    logic [IW-1:0]      clr_reg, clr_next;
    logic [31:0]        peak_reg, peak_next;
    logic [DIV_W-1:0]   num_reg, num_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic [SIZE_W-1:0]  r_reg, r_next;
    logic [1:0]         ch_reg, ch_next;
    logic [23:0]        acc_reg, acc_next;
    logic               res_valid_reg, res_valid_next;
    logic [23:0]        res_reg, res_next;
    logic               res_load;

    logic [23:0]        pal_mem_reg [PALETTE_DEPTH];
    logic [23:0]        rd_a_reg, rd_b_reg;
    logic               pal_we;
    logic [PW-1:0]      addr_a, addr_b;
    logic [SIZE_W-1:0]  r_inc;

    logic [31:0]        hist_mem_reg [MAX_ITERATIONS];
    logic [31:0]        hist_rd_reg;
    logic               hist_we;
    logic [IW-1:0]      hist_waddr;
    logic [31:0]        hist_wdata;
    logic [31:0]        hist_inc;

    logic               div_start;
    logic [DIV_W-1:0]   div_dvd;
    logic [REM_W-1:0]   div_dvs;
    div_stat_t          div_stat;
    logic [DIV_W-1:0]   div_quo;
    logic [REM_W-1:0]   div_rem;

    logic [SIZE_W+19:0] dist_prod;
    logic [31:0]        hist_cnt;

    logic [7:0]         ch_a, ch_b;
    logic signed [8:0]  ch_diff;
    logic signed [27:0] ch_prod;
    logic [9:0]         ch_sum;

    etpc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // palette read addresses follow the latched remainder
    assign r_inc  = (r_reg + 1'b1 == cur_reg.size) ? '0 : r_reg + 1'b1;
    assign addr_a = (cur_reg.kind == K_ESCAPE) ? PW'(cur_reg.size - 1'b1 - r_reg) : PW'(r_reg);
    assign addr_b = PW'(r_inc);

    // saturating count increment
    assign hist_inc  = (hist_rd_reg == 32'hFFFFFFFF) ? hist_rd_reg : hist_rd_reg + 1'b1;
    assign hist_cnt  = cur_reg.hit ? hist_rd_reg : '0;
    assign dist_prod = (SIZE_W+20)'(cur_reg.size) * (SIZE_W+20)'(cur_reg.dist_est);

    // one channel of the distance blend
    assign ch_a    = rd_a_reg[ch_reg*8 +: 8];
    assign ch_b    = rd_b_reg[ch_reg*8 +: 8];
    assign ch_diff = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
    assign ch_prod = ch_diff * $signed({1'b0, frac_reg});
    assign ch_sum  = 10'(ch_a) + ch_prod[27:18];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        init_next      = init_reg;
        clr_next       = clr_reg;
        peak_next      = peak_reg;
        num_next       = num_reg;
        frac_next      = frac_reg;
        r_next         = r_reg;
        ch_next        = ch_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        res_load       = 1'b0;
        q_rd           = 1'b0;
        pal_we         = 1'b0;
        hist_we        = 1'b0;
        hist_waddr     = IW'(cur_reg.iter);
        hist_wdata     = hist_inc;
        div_start      = 1'b0;
        div_dvd        = num_reg;
        div_dvs        = REM_W'(cur_reg.size);
        unique case (state_reg)
            ST_CLEAR:
            begin
                hist_we    = 1'b1;
                hist_waddr = clr_reg;
                hist_wdata = '0;
                peak_next  = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == IW'(MAX_ITERATIONS - 1))
                begin
                    init_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    case (head.kind)
                        K_WRITE:
                        begin
                            pal_we = 1'b1;
                            q_rd   = 1'b1;
                        end
                        K_CLEAR:
                        begin
                            q_rd       = 1'b1;
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        K_COUNT:
                        begin
                            q_rd       = 1'b1;
                            cur_next   = head;
                            state_next = ST_CNT_RD;
                        end
                        default:
                        begin
                            if (!res_valid_reg)
                            begin
                                q_rd     = 1'b1;
                                cur_next = head;
                                num_next = DIV_W'(head.iter);
                                case (head.kind)
                                    K_ESCAPE: state_next = ST_MOD_START;
                                    K_DIST:   state_next = ST_MUL;
                                    K_HIST:   state_next = ST_HRD;
                                    default:
                                    begin
                                        res_load = 1'b1;
                                        res_next = head.rgb;
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
            ST_CNT_RD:
            begin
                state_next = ST_CNT_WR;
            end
            ST_CNT_WR:
            begin
                hist_we = 1'b1;
                if (hist_inc > peak_reg)
                begin
                    peak_next = hist_inc;
                end
                state_next = ST_IDLE;
            end
            ST_MUL:
            begin
                frac_next  = dist_prod[FRAC_W-1:0];
                num_next   = DIV_W'(dist_prod[SIZE_W+19:FRAC_W]);
                state_next = ST_MOD_START;
            end
            ST_HRD:
            begin
                state_next = ST_HMUL;
            end
            ST_HMUL:
            begin
                if (peak_reg == '0)
                begin
                    num_next   = '0;
                    state_next = ST_MOD_START;
                end
                else
                begin
                    num_next   = DIV_W'(hist_cnt) * DIV_W'(HIST_SCALE);
                    state_next = ST_QSTART;
                end
            end
            ST_QSTART:
            begin
                div_start  = 1'b1;
                div_dvs    = peak_reg;
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (div_stat.done)
                begin
                    num_next   = div_quo;
                    state_next = ST_MOD_START;
                end
            end
            ST_MOD_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (div_stat.done)
                begin
                    r_next     = div_rem[SIZE_W-1:0];
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (cur_reg.kind == K_DIST)
                begin
                    ch_next    = '0;
                    state_next = ST_BLEND;
                end
                else
                begin
                    res_load   = 1'b1;
                    res_next   = rd_a_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_BLEND:
            begin
                acc_next[ch_reg*8 +: 8] = ch_sum[7:0];
                ch_next                 = ch_reg + 1'b1;
                if (ch_reg == 2'd2)
                begin
                    res_load   = 1'b1;
                    res_next   = {ch_sum[7:0], acc_reg[15:0]};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            init_reg      <= 1'b1;
            clr_reg       <= '0;
            peak_reg      <= '0;
            ch_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            clr_reg       <= clr_next;
            peak_reg      <= peak_next;
            ch_reg        <= ch_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        num_reg  <= num_next;
        frac_reg <= frac_next;
        r_reg    <= r_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    // palette memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem_reg[PW'(head.entry)] <= head.rgb;
        end
        rd_a_reg <= pal_mem_reg[addr_a];
        rd_b_reg <= pal_mem_reg[addr_b];
    end

    // histogram memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem_reg[hist_waddr] <= hist_wdata;
        end
        hist_rd_reg <= hist_mem_reg[IW'(cur_reg.iter)];
    end

    assign init_busy = init_reg;
    assign empty     = !res_valid_reg;
    assign pixel_rgb = res_reg;

    // checks
    `ETPC_ASSERT(a_res_free, res_load, !res_valid_reg)
    `ETPC_ASSERT(a_div_idle, div_start, !div_stat.busy)
    `ETPC_ASSERT_NEXT(a_clear_peak, state_reg == ST_CLEAR, peak_reg == '0)

endmodule

@@ src/escape_time_palette_colorer_core.sv @@
// Escape time palette colorer: front classifier, task queue, back sequencer.
// Escape colors take a modulo; distance a multiply, then the modulo; histogram a
// scaled divide, then the modulo. One item at a time in the back; the shared
// divider sets the rate of palette-indexed colors. Reset: all control cleared,
// then a histogram clearing pass over all MAX_ITERATIONS entries with full held
// high; the palette holds nothing until written.
module escape_time_palette_colorer_core
    import etpc_pkg::*;
#(
    parameter int PALETTE_DEPTH  = PALETTE_DEPTH_DEF,
    parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic        converged,
    input  logic [9:0]  iteration_count,
    input  logic [19:0] distance_estimate,
    input  logic [7:0]  entry_index,
    input  logic [23:0] entry_rgb,
    output logic        empty,
    input  logic        pop,
    output logic [23:0] pixel_rgb
);

    logic    q_wr;
    logic    q_rd;
    task_t   q_wdata;
    task_t   q_head;
    q_stat_t q_stat;
    logic    init_busy;

    // hold off input words during the clearing pass after reset
    assign full = q_stat.full || init_busy;

    etpc_front #(
        .PALETTE_DEPTH  (PALETTE_DEPTH),
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .push              (push),
        .full              (full),
        .opcode            (opcode),
        .converged         (converged),
        .iteration_count   (iteration_count),
        .distance_estimate (distance_estimate),
        .entry_index       (entry_index),
        .entry_rgb         (entry_rgb),
        .q_wr              (q_wr),
        .q_wdata           (q_wdata)
    );

    etpc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .rd    (q_rd),
        .head  (q_head),
        .stat  (q_stat)
    );

    etpc_back #(
        .PALETTE_DEPTH  (PALETTE_DEPTH),
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_stat    (q_stat),
        .q_rd      (q_rd),
        .init_busy (init_busy),
        .empty     (empty),
        .pop       (pop),
        .pixel_rgb (pixel_rgb)
    );

endmodule
